// ===== rtl/mdts_pkg.sv =====
// mdts_pkg: constants, widths and character helpers for the method descriptor
// to shorty converter. No dependencies; imported by the core module.

package mdts_pkg;

  // limits of the descriptor grammar
  localparam int MAX_PARAMS     = 63;
  localparam int MAX_ARRAY_DIMS = 255;

  // widths derived from the limits
  localparam int PCNT_W  = $clog2(MAX_PARAMS + 1);
  localparam int IDX_W   = $clog2(MAX_PARAMS);
  localparam int DEPTH_W = $clog2(MAX_ARRAY_DIMS + 2);

  // stream widths
  localparam int CHAR_W      = 8;
  localparam int LETTER_W    = 7;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 8;

  // descriptor characters
  localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;
  localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_V      = 8'h56;
  localparam logic [CHAR_W-1:0] CH_L      = 8'h4C;

  // shorty letter for class and array types
  localparam logic [LETTER_W-1:0] LETTER_L    = 7'h4C;
  localparam logic [LETTER_W-1:0] LETTER_NONE = 7'h00;

  // primitive type letters Z B C S I J F D
  function automatic logic is_prim(input logic [CHAR_W-1:0] c);
    logic r;
    case (c) inside
      8'h5A, 8'h42, 8'h43, 8'h53, 8'h49, 8'h4A, 8'h46, 8'h44: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/method_descriptor_to_shorty_core.sv =====
// method_descriptor_to_shorty_core: grammar check of a method descriptor and
// shorty emission from a parameter letter buffer. Depends on mdts_pkg.
//
// channel | dir | tdata                     | tuser | tlast
// in_     | in  | [7:0] sig_char            | -     | end_of_string
// out_    | out | [6:0] letter, [7] zero    | ok    | last_result
//
// one descriptor character is taken every cycle while parsing
// the final character moves the block into a drain of 1 + param_count results
// (1 on error), one per cycle while out_tready is high; in_tready is low then
// the letter buffer ram has a registered read, hidden by reading one entry ahead
// reset is synchronous and active low; the letter buffer needs no clearing
// a stalled result is held in the output register; the drain waits, parsing does not

module method_descriptor_to_shorty_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [mdts_pkg::IN_TDATA_W-1:0]    in_tdata,   // [7:0] sig_char
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [mdts_pkg::OUT_TDATA_W-1:0]   out_tdata,  // [6:0] letter, [7] zero
  output logic                               out_tuser,  // [0] ok
  output logic                               out_tlast
);

  import mdts_pkg::*;

  typedef enum logic [2:0] {
    PH_OPEN, PH_PARAM, PH_PCLASS, PH_PARRAY, PH_RET, PH_RCLASS, PH_RARRAY, PH_DONE
  } phase_t;

  typedef enum logic {
    S_PARSE, S_DRAIN
  } ctrl_t;

  // parser state
  phase_t               phase_r, phase_nxt;
  logic [DEPTH_W-1:0]   depth_r, depth_nxt;
  logic                 seen_r, seen_nxt;
  logic                 slash_r, slash_nxt;
  logic [PCNT_W-1:0]    pcnt_r, pcnt_nxt;
  logic [LETTER_W-1:0]  ret_r, ret_nxt;
  logic                 failed_r, failed_nxt;

  // letter buffer
  logic [LETTER_W-1:0]  mem [MAX_PARAMS];
  logic                 wr_en;
  logic [LETTER_W-1:0]  wr_letter;
  logic [IDX_W-1:0]     rd_addr;
  logic [LETTER_W-1:0]  rd_data_r;

  // drain control and output register
  ctrl_t                state_r;
  logic                 v_ok_r;
  logic [LETTER_W-1:0]  v_ret_r;
  logic [PCNT_W-1:0]    v_cnt_r;
  logic                 ret_pend_r;
  logic [IDX_W-1:0]     idx_r;
  logic                 out_valid_r;
  logic [LETTER_W-1:0]  out_letter_r;
  logic                 out_ok_r;
  logic                 out_last_r;

  logic                 in_acc;
  logic                 end_acc;
  logic                 slot_free;
  logic                 emit;
  logic                 advance;
  logic                 param_last;
  logic                 verdict_ok;

  assign in_tready  = (state_r == S_PARSE);
  assign in_acc     = in_tvalid && in_tready;
  assign end_acc    = in_acc && in_tlast;
  assign slot_free  = !out_valid_r || out_tready;
  assign emit       = (state_r == S_DRAIN) && slot_free;
  assign param_last = ((PCNT_W'(idx_r) + PCNT_W'(1)) == v_cnt_r);
  assign advance    = emit && !ret_pend_r && !param_last;

  // read one entry ahead so the next letter is ready when the slot frees
  assign rd_addr = advance ? (idx_r + IDX_W'(1)) : idx_r;

  // grammar step on one character
  always_comb begin
    logic [CHAR_W-1:0]   c;
    logic                in_ret;
    logic                fin;
    logic [LETTER_W-1:0] fin_letter;
    c          = in_tdata;
    in_ret     = (phase_r == PH_RET) || (phase_r == PH_RCLASS) || (phase_r == PH_RARRAY);
    fin        = 1'b0;
    fin_letter = LETTER_L;
    phase_nxt  = phase_r;
    depth_nxt  = depth_r;
    seen_nxt   = seen_r;
    slash_nxt  = slash_r;
    pcnt_nxt   = pcnt_r;
    ret_nxt    = ret_r;
    failed_nxt = failed_r;
    wr_en      = 1'b0;
    wr_letter  = LETTER_L;
    if (!failed_r) begin
      unique case (phase_r) inside
        PH_OPEN: begin
          if (c == CH_LPAREN) phase_nxt = PH_PARAM;
          else failed_nxt = 1'b1;
        end
        PH_PARAM, PH_RET: begin
          if (phase_r == PH_PARAM && c == CH_RPAREN) begin
            phase_nxt = PH_RET;
          end else if (is_prim(c) || (in_ret && c == CH_V)) begin
            fin        = 1'b1;
            fin_letter = c[LETTER_W-1:0];
          end else if (c == CH_L) begin
            seen_nxt  = 1'b0;
            slash_nxt = 1'b0;
            phase_nxt = in_ret ? PH_RCLASS : PH_PCLASS;
          end else if (c == CH_LBRACK) begin
            depth_nxt = DEPTH_W'(1);
            phase_nxt = in_ret ? PH_RARRAY : PH_PARRAY;
          end else begin
            failed_nxt = 1'b1;
          end
        end
        PH_PCLASS, PH_RCLASS: begin
          if (c == CH_SEMI) begin
            if (!seen_r || slash_r) failed_nxt = 1'b1;
            else fin = 1'b1;
          end else if (c == CH_LPAREN || c == CH_RPAREN || c == CH_LBRACK || c == CH_DOT) begin
            failed_nxt = 1'b1;
          end else if (c == CH_SLASH) begin
            if (!seen_r || slash_r) failed_nxt = 1'b1;
            seen_nxt  = 1'b1;
            slash_nxt = 1'b1;
          end else begin
            seen_nxt  = 1'b1;
            slash_nxt = 1'b0;
          end
        end
        PH_PARRAY, PH_RARRAY: begin
          if (c == CH_LBRACK) begin
            depth_nxt = depth_r + DEPTH_W'(1);
            if (depth_nxt > DEPTH_W'(MAX_ARRAY_DIMS)) failed_nxt = 1'b1;
          end else if (is_prim(c)) begin
            fin = 1'b1;
          end else if (c == CH_L) begin
            seen_nxt  = 1'b0;
            slash_nxt = 1'b0;
            phase_nxt = in_ret ? PH_RCLASS : PH_PCLASS;
          end else begin
            failed_nxt = 1'b1;
          end
        end
        default: failed_nxt = 1'b1;
      endcase
      // a finished type goes to the return letter or the buffer, or fails the descriptor when the buffer is full
      if (fin) begin
        if (in_ret) begin
          ret_nxt   = fin_letter;
          phase_nxt = PH_DONE;
        end else if (pcnt_r >= PCNT_W'(MAX_PARAMS)) begin
          failed_nxt = 1'b1;
        end else begin
          wr_en     = 1'b1;
          wr_letter = fin_letter;
          pcnt_nxt  = pcnt_r + PCNT_W'(1);
          phase_nxt = PH_PARAM;
        end
      end
    end
  end

  assign verdict_ok = !failed_nxt && (phase_nxt == PH_DONE);

  // parser registers, cleared at the end of each descriptor
  always_ff @(posedge clk) begin
    if (!rst_n || end_acc) begin
      phase_r  <= PH_OPEN;
      depth_r  <= '0;
      seen_r   <= 1'b0;
      slash_r  <= 1'b0;
      pcnt_r   <= '0;
      ret_r    <= LETTER_NONE;
      failed_r <= 1'b0;
    end else if (in_acc) begin
      phase_r  <= phase_nxt;
      depth_r  <= depth_nxt;
      seen_r   <= seen_nxt;
      slash_r  <= slash_nxt;
      pcnt_r   <= pcnt_nxt;
      ret_r    <= ret_nxt;
      failed_r <= failed_nxt;
    end
  end

  // letter buffer ram, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (in_acc && wr_en) begin
      mem[pcnt_r[IDX_W-1:0]] <= wr_letter;
    end
    rd_data_r <= mem[rd_addr];
  end

  // drain sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_PARSE;
      ret_pend_r  <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_tready && !emit) out_valid_r <= 1'b0;
      unique case (state_r)
        S_PARSE: begin
          if (end_acc) begin
            state_r    <= S_DRAIN;
            v_ok_r     <= verdict_ok;
            v_ret_r    <= ret_nxt;
            v_cnt_r    <= pcnt_r;
            ret_pend_r <= 1'b1;
            idx_r      <= '0;
          end
        end
        S_DRAIN: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            if (ret_pend_r) begin
              ret_pend_r   <= 1'b0;
              out_letter_r <= v_ok_r ? v_ret_r : LETTER_NONE;
              out_ok_r     <= v_ok_r;
              out_last_r   <= !v_ok_r || (v_cnt_r == '0);
              if (!v_ok_r || (v_cnt_r == '0)) state_r <= S_PARSE;
            end else begin
              out_letter_r <= rd_data_r;
              out_ok_r     <= 1'b1;
              out_last_r   <= param_last;
              if (param_last) state_r <= S_PARSE;
              else idx_r <= idx_r + IDX_W'(1);
            end
          end
        end
        default: state_r <= S_PARSE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_letter_r};
  assign out_tuser  = out_ok_r;
  assign out_tlast  = out_last_r;

  // the final character always starts a drain
  a_end_starts_drain: assert property (@(posedge clk) disable iff (!rst_n)
    end_acc |=> (state_r == S_DRAIN))
    else $error("final character did not start a drain");

  // an error result is the only result of its descriptor
  a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ok_r) |-> out_last_r)
    else $error("error result not marked last");

  // the buffer index stays below the stored count while draining letters
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DRAIN) && !ret_pend_r) |-> (PCNT_W'(idx_r) < v_cnt_r))
    else $error("drain index beyond parameter count");

  // the parameter count never exceeds the buffer depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pcnt_r <= PCNT_W'(MAX_PARAMS))
    else $error("parameter count overflow");

  // no character is taken while a drain is running
  a_no_input_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN) |-> !in_acc)
    else $error("character accepted during drain");

endmodule
